// ===== rtl/sss_pkg.sv =====
`default_nettype none
package sss_pkg;
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_PULL   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_output;
    logic       nothing_left;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    logic clear_set;
    logic append;
    logic cmp_start;
    logic cmp_step;
    logic shift_row;
    logic place_row;
    logic drop_close;
    logic pull_start;
    logic pull_read;
    logic pull_emit;
  } ctl_t;

  typedef struct packed {
    logic emitting;
    logic full;
    logic cmp_done;
    logic row_after;
    logic pos_zero;
    logic copy_done;
    logic place_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/string_set_sorter.sv =====
`default_nettype none
// an append is registered into the pending string as it is taken; a pull result strobes
// once the controller has passed from S_READ into S_EMIT; close stays busy through a
// byte compare then row shift for each stored string it passes, then a last compare and place
// one item at a time while busy is high, appends every cycle while busy is low, a new
// pull only once the previous result has strobed; the receiver cannot stall, each result strobes once
// reset: synchronous active-high rst empties the set and clears truncated
module string_set_sorter #(
  parameter int MAX_STRINGS = 16,
  parameter int MAX_LENGTH  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire sss_pkg::in_item_t   item,
  output logic                     busy,
  output logic                     strobe,
  output sss_pkg::out_item_t       result
);
  import sss_pkg::*;

  ctl_t ctl;
  sts_t sts;

  sss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(item.command),
    .sts(sts), .busy(busy), .strobe(strobe), .ctl(ctl)
  );

  sss_datapath #(.MAX_STRINGS(MAX_STRINGS), .MAX_LENGTH(MAX_LENGTH)) u_dp (
    .clk(clk), .rst(rst), .character(item.character),
    .ctl(ctl), .sts(sts), .result(result)
  );
endmodule
`default_nettype wire

// ===== rtl/sss_ram.sv =====
`default_nettype none
module sss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/sss_datapath.sv =====
`default_nettype none
module sss_datapath #(
  parameter int MAX_STRINGS = 16,
  parameter int MAX_LENGTH  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         character,
  input  wire sss_pkg::ctl_t      ctl,
  output sss_pkg::sts_t           sts,
  output sss_pkg::out_item_t      result
);
  import sss_pkg::*;

  localparam int SW = $clog2(MAX_STRINGS);
  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int CW = $clog2(MAX_STRINGS + 1);
  localparam int PW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int AW = SW + PW;
  localparam int DEPTH = MAX_STRINGS * (2 ** PW);

  logic [LW-1:0] lengths [MAX_STRINGS];
  logic [CW-1:0] count;
  logic [LW-1:0] pend_len;
  logic [CW-1:0] rd_str;
  logic [LW-1:0] rd_pos;
  logic          emitting;
  logic          overflow;
  logic [CW-1:0] pos;
  logic [LW-1:0] idx;
  logic          after;
  logic          done;
  logic          was_read;

  logic [7:0] pend_q [MAX_LENGTH];

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  sss_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [SW-1:0] row_prev, row_cur, row_rd;
  logic [PW-1:0] idx_p;
  logic [LW-1:0] len_prev, min_len;
  logic [LW-1:0] pend_base;
  assign row_prev  = SW'(pos - CW'(1));
  assign row_cur   = SW'(pos);
  assign row_rd    = SW'(rd_str);
  assign idx_p     = PW'(idx);
  assign len_prev  = lengths[row_prev];
  assign min_len   = (len_prev < pend_len) ? len_prev : pend_len;
  assign pend_base = ctl.clear_set ? LW'(0) : pend_len;

  always_comb begin
    raddr = {row_prev, idx_p};
    if (ctl.pull_read) raddr = {row_rd, PW'(rd_pos)};
    we    = 1'b0;
    waddr = {row_cur, idx_p};
    wdata = rdata;
    if (ctl.shift_row && was_read) we = 1'b1;
    if (ctl.place_row) begin
      we    = idx < pend_len;
      wdata = pend_q[idx_p];
    end
  end

  // compare walks the bytes one at a time: address, then data
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pend_len <= '0;
      rd_str   <= '0;
      rd_pos   <= '0;
      emitting <= 1'b0;
      overflow <= 1'b0;
      pos      <= '0;
      idx      <= '0;
      after    <= 1'b0;
      done     <= 1'b0;
      was_read <= 1'b0;
      for (int i = 0; i < MAX_STRINGS; i++) lengths[i] <= '0;
    end else begin
      if (ctl.clear_set) begin
        count <= '0; rd_str <= '0; rd_pos <= '0; emitting <= 1'b0;
      end
      if (ctl.append) begin
        if (pend_base < LW'(MAX_LENGTH)) begin
          pend_q[PW'(pend_base)] <= character;
          pend_len <= pend_base + LW'(1);
        end else overflow <= 1'b1;
      end
      if (ctl.drop_close) begin
        overflow <= 1'b1; pend_len <= '0;
      end
      if (ctl.cmp_start) begin
        pos <= ctl.clear_set ? '0 : count;
        if (ctl.clear_set) pend_len <= '0;
        idx <= '0; done <= 1'b0; after <= 1'b0; was_read <= 1'b0;
      end
      if (ctl.cmp_step) begin
        if (!was_read) begin
          if (idx >= min_len) begin
            done <= 1'b1; after <= len_prev > pend_len; idx <= '0;
          end else was_read <= 1'b1;
        end else begin
          was_read <= 1'b0;
          if (rdata != pend_q[idx_p]) begin
            done <= 1'b1; after <= rdata > pend_q[idx_p]; idx <= '0;
          end else idx <= idx + LW'(1);
        end
      end
      if (ctl.shift_row) begin
        if (!was_read) was_read <= 1'b1;
        else begin
          was_read <= 1'b0;
          if (idx == LW'(MAX_LENGTH - 1)) begin
            idx <= '0; lengths[row_cur] <= len_prev; pos <= pos - CW'(1);
            done <= 1'b0; after <= 1'b0;
          end else idx <= idx + LW'(1);
        end
      end
      if (ctl.place_row) begin
        if (idx == LW'(MAX_LENGTH - 1)) begin
          lengths[row_cur] <= pend_len; count <= count + CW'(1);
          pend_len <= '0; idx <= '0;
        end else idx <= idx + LW'(1);
      end
      if (ctl.pull_start && !emitting) begin
        emitting <= 1'b1; pend_len <= '0; rd_str <= '0; rd_pos <= '0;
      end
      if (ctl.pull_emit && rd_str < count) begin
        if (rd_pos < lengths[row_rd]) rd_pos <= rd_pos + LW'(1);
        else begin
          rd_str <= rd_str + CW'(1); rd_pos <= '0;
        end
      end
    end
  end

  always_comb begin
    result = '0;
    result.truncated = overflow;
    if (rd_str >= count) result.nothing_left = 1'b1;
    else if (rd_pos < lengths[row_rd]) result.out_char = rdata;
    else begin
      result.out_char = NEWLINE_CHAR;
      result.end_of_output = (rd_str + CW'(1)) == count;
    end
  end

  assign sts.emitting   = emitting;
  assign sts.full       = count >= CW'(MAX_STRINGS);
  assign sts.cmp_done   = done;
  assign sts.row_after  = after;
  assign sts.pos_zero   = pos == '0;
  assign sts.copy_done  = was_read && (idx == LW'(MAX_LENGTH - 1));
  assign sts.place_done = idx == LW'(MAX_LENGTH - 1);

  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_STRINGS))
    else $error("count over capacity");
  a_pend: assert property (@(posedge clk) disable iff (rst) pend_len <= LW'(MAX_LENGTH))
    else $error("pending over capacity");
  a_cursor: assert property (@(posedge clk) disable iff (rst) rd_str <= count)
    else $error("cursor past count");
endmodule
`default_nettype wire

// ===== rtl/sss_ctrl.sv =====
`default_nettype none
module sss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      command,
  input  wire sss_pkg::sts_t   sts,
  output logic                 busy,
  output logic                 strobe,
  output sss_pkg::ctl_t        ctl
);
  import sss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CMP   = 6'b000010,
    S_SHIFT = 6'b000100,
    S_PLACE = 6'b001000,
    S_READ  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   go;
  assign go = start && !busy;
  assign busy = state != S_IDLE;
  assign strobe = state == S_EMIT;

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: if (go) begin
        unique case (cmd_t'(command))
          CMD_APPEND: begin
            ctl.clear_set = sts.emitting; ctl.append = 1'b1;
          end
          CMD_CLOSE: begin
            ctl.clear_set = sts.emitting;
            if (sts.full && !sts.emitting) ctl.drop_close = 1'b1;
            else begin
              ctl.cmp_start = 1'b1; state_next = S_CMP;
            end
          end
          CMD_PULL: begin
            ctl.pull_start = 1'b1; state_next = S_READ;
          end
          default: ;
        endcase
      end
      S_CMP: begin
        if (sts.pos_zero) state_next = S_PLACE;
        else if (sts.cmp_done) state_next = sts.row_after ? S_SHIFT : S_PLACE;
        else ctl.cmp_step = 1'b1;
      end
      S_SHIFT: begin
        ctl.shift_row = 1'b1;
        if (sts.copy_done) state_next = S_CMP;
      end
      S_PLACE: begin
        ctl.place_row = 1'b1;
        if (sts.place_done) state_next = S_IDLE;
      end
      S_READ: begin
        ctl.pull_read = 1'b1; state_next = S_EMIT;
      end
      S_EMIT: begin
        ctl.pull_emit = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_strobe: assert property (@(posedge clk) disable iff (rst) strobe |-> $past(state) == S_READ)
    else $error("strobe without read");
  a_busy: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("double strobe");
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
endmodule
`default_nettype wire
